/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define QRS_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define QRS_ASSERT(lbl, clk, rst_n, prop)
`define QRS_ASSERT_RST(lbl, clk, prop)
`endif
`endif

/* hw/rtl/qrs_pkg.sv */
// Shared types for the quadratic root solver.
// No dependencies.
package qrs_pkg;

  typedef enum logic [1:0] {
    ST_ROOTS    = 2'd0,
    ST_NEG_DISC = 2'd1,
    ST_A_ZERO   = 2'd2
  } status_e;

endpackage

/* hw/rtl/qrs_isqrt.sv */
// Pipelined floor square root, one result bit per stage.
// Uses qrs_pkg; carries a side payload along the stages.
module qrs_isqrt import qrs_pkg::*; #(
  parameter int NW = 66,
  parameter int PW = 67
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NW-1:0]     rad_i,
  input  logic [PW-1:0]     pass_i,
  output logic              valid_o,
  output logic [NW/2-1:0]   root_o,
  output logic [PW-1:0]     pass_o
);

  localparam int RW = NW / 2;

  logic              v_q    [RW];
  logic [NW-1:0]     rad_q  [RW];
  logic [RW+1:0]     rem_q  [RW];
  logic [RW-1:0]     root_q [RW];
  logic [PW-1:0]     pass_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stg
    logic          pv;
    logic [NW-1:0] prad;
    logic [RW+1:0] prem;
    logic [RW-1:0] proot;
    logic [PW-1:0] ppass;
    logic [RW+2:0] sh;
    logic [RW+2:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign pv    = valid_i;
      assign prad  = rad_i;
      assign prem  = '0;
      assign proot = '0;
      assign ppass = pass_i;
    end else begin : g_next
      assign pv    = v_q[k-1];
      assign prad  = rad_q[k-1];
      assign prem  = rem_q[k-1];
      assign proot = root_q[k-1];
      assign ppass = pass_q[k-1];
    end

    assign sh    = {prem[RW:0], prad[NW-1 -: 2]};
    assign trial = {1'b0, proot, 2'b01};
    assign ge    = (sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {prad[NW-3:0], 2'b00};
        rem_q[k]  <= ge ? (RW+2)'(sh - trial) : sh[RW+1:0];
        root_q[k] <= {proot[RW-2:0], ge};
        pass_q[k] <= ppass;
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign pass_o  = pass_q[RW-1];

endmodule

/* hw/rtl/qrs_div.sv */
// Pipelined two-lane restoring divider with a shared divisor.
// Uses qrs_pkg; one quotient bit per lane per stage.
module qrs_div import qrs_pkg::*; #(
  parameter int NW = 50,
  parameter int DW = 33,
  parameter int PW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_p_i,
  input  logic [NW-1:0] num_m_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [PW-1:0] pass_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_p_o,
  output logic [NW-1:0] quo_m_o,
  output logic [PW-1:0] pass_o
);

  logic          v_q    [NW];
  logic [NW-1:0] nqp_q  [NW];
  logic [NW-1:0] nqm_q  [NW];
  logic [DW-1:0] remp_q [NW];
  logic [DW-1:0] remm_q [NW];
  logic [DW-1:0] div_q  [NW];
  logic [PW-1:0] pass_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stg
    logic          pv;
    logic [NW-1:0] pnqp;
    logic [NW-1:0] pnqm;
    logic [DW-1:0] premp;
    logic [DW-1:0] premm;
    logic [DW-1:0] pdiv;
    logic [PW-1:0] ppass;
    logic [DW:0]   shp;
    logic [DW:0]   shm;
    logic          gep;
    logic          gem;

    if (k == 0) begin : g_first
      assign pv    = valid_i;
      assign pnqp  = num_p_i;
      assign pnqm  = num_m_i;
      assign premp = '0;
      assign premm = '0;
      assign pdiv  = divisor_i;
      assign ppass = pass_i;
    end else begin : g_next
      assign pv    = v_q[k-1];
      assign pnqp  = nqp_q[k-1];
      assign pnqm  = nqm_q[k-1];
      assign premp = remp_q[k-1];
      assign premm = remm_q[k-1];
      assign pdiv  = div_q[k-1];
      assign ppass = pass_q[k-1];
    end

    assign shp = {premp, pnqp[NW-1]};
    assign shm = {premm, pnqm[NW-1]};
    assign gep = (shp >= {1'b0, pdiv});
    assign gem = (shm >= {1'b0, pdiv});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nqp_q[k]  <= {pnqp[NW-2:0], gep};
        nqm_q[k]  <= {pnqm[NW-2:0], gem};
        remp_q[k] <= gep ? DW'(shp - {1'b0, pdiv}) : shp[DW-1:0];
        remm_q[k] <= gem ? DW'(shm - {1'b0, pdiv}) : shm[DW-1:0];
        div_q[k]  <= pdiv;
        pass_q[k] <= ppass;
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo_p_o = nqp_q[NW-1];
  assign quo_m_o = nqm_q[NW-1];
  assign pass_o  = pass_q[NW-1];

endmodule

/* hw/rtl/quadratic_root_solver_core.sv */
// Quadratic real-root solver: exact discriminant, floor square root, two divides.
// Accepts one transfer per cycle while s_axis_tready is high; a full skid stage stalls the pipeline.
// Depth is set by the square root (DATA_WIDTH+1 stages) and the divider
// (DATA_WIDTH+2+FRAC_BITS stages). An output register plus skid stage keep
// s_axis_tready registered. Reset empties the pipeline; no clearing pass.
`include "assert_macros.svh"
module quadratic_root_solver_core import qrs_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // coef_a, coef_b, coef_c from bit 0 up, zero fill
  input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // root_plus, root_minus from bit 0 up, zero fill
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  // status
  output logic [1:0]                             m_axis_tuser
);

  localparam int W      = DATA_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int OTW    = ((2*W+7)/8)*8;
  localparam int DISCW  = 2*W + 2;
  localparam int RW     = W + 1;
  localparam int MW     = W + 2;
  localparam int NW     = MW + F;
  localparam int SPW    = 2 + 1 + W + W;
  localparam int DPW    = 2 + 1 + 1;
  localparam int ODW    = 2 + 2*W;

  logic en;

  // stage 1: magnitudes and products
  logic signed [W-1:0] a_in, b_in, c_in;
  logic [W-1:0]        a_abs, b_abs, c_abs;

  assign a_in  = s_axis_tdata[W-1:0];
  assign b_in  = s_axis_tdata[2*W-1:W];
  assign c_in  = s_axis_tdata[3*W-1:2*W];
  assign a_abs = a_in[W-1] ? W'(-a_in) : a_in;
  assign b_abs = b_in[W-1] ? W'(-b_in) : b_in;
  assign c_abs = c_in[W-1] ? W'(-c_in) : c_in;

  logic           v1_q;
  logic [2*W-1:0] bsq_q, ac_q;
  logic [W-1:0]   aabs1_q, b1_q;
  logic           aneg1_q, azero1_q, add1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bsq_q    <= (2*W)'(b_abs) * (2*W)'(b_abs);
      ac_q     <= (2*W)'(a_abs) * (2*W)'(c_abs);
      aabs1_q  <= a_abs;
      b1_q     <= b_in;
      aneg1_q  <= a_in[W-1];
      azero1_q <= (a_in == '0);
      add1_q   <= (a_in[W-1] != c_in[W-1]) || (c_in == '0);
    end
  end

  // stage 2: discriminant
  logic [DISCW-1:0] fac, bsq_x, disc_d;
  status_e          st2_d;

  assign fac   = {ac_q, 2'b00};
  assign bsq_x = {2'b00, bsq_q};

  always_comb begin
    disc_d = bsq_x - fac;
    st2_d  = ST_ROOTS;
    if (add1_q) begin
      disc_d = bsq_x + fac;
    end else if (fac > bsq_x) begin
      st2_d = ST_NEG_DISC;
    end
    if (azero1_q) begin
      st2_d = ST_A_ZERO;
    end
  end

  logic             v2_q;
  logic [DISCW-1:0] disc_q;
  logic [SPW-1:0]   sp2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      disc_q <= disc_d;
      sp2_q  <= {st2_d, aneg1_q, aabs1_q, b1_q};
    end
  end

  logic           vs;
  logic [RW-1:0]  root_s;
  logic [SPW-1:0] sp_s;

  qrs_isqrt #(.NW(DISCW), .PW(SPW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .rad_i   (disc_q),
    .pass_i  (sp2_q),
    .valid_o (vs),
    .root_o  (root_s),
    .pass_o  (sp_s)
  );

  // stage 3: numerators
  logic signed [W+2:0] bx, dx, np, nm;
  logic [W-1:0]        aabs_s;
  logic                aneg_s;
  logic [1:0]          st_s;

  assign st_s   = sp_s[SPW-1 -: 2];
  assign aneg_s = sp_s[2*W];
  assign aabs_s = sp_s[2*W-1:W];
  assign bx     = {{3{sp_s[W-1]}}, sp_s[W-1:0]};
  assign dx     = {2'b00, root_s};
  assign np     = dx - bx;
  assign nm     = -bx - dx;

  logic           v3_q;
  logic [MW-1:0]  magp_q, magm_q;
  logic [W:0]     divs_q;
  logic [DPW-1:0] dp3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      magp_q <= np[W+2] ? MW'(-np) : np[MW-1:0];
      magm_q <= nm[W+2] ? MW'(-nm) : nm[MW-1:0];
      divs_q <= {aabs_s, 1'b0};
      dp3_q  <= {st_s, np[W+2] ^ aneg_s, nm[W+2] ^ aneg_s};
    end
  end

  logic           vd;
  logic [NW-1:0]  qp, qm;
  logic [DPW-1:0] dp_d;

  qrs_div #(.NW(NW), .DW(W+1), .PW(DPW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (v3_q),
    .num_p_i   ({magp_q, {F{1'b0}}}),
    .num_m_i   ({magm_q, {F{1'b0}}}),
    .divisor_i (divs_q),
    .pass_i    (dp3_q),
    .valid_o   (vd),
    .quo_p_o   (qp),
    .quo_m_o   (qm),
    .pass_o    (dp_d)
  );

  // stage 4: sign and saturation
  localparam logic [NW-1:0] HALF_Q = {{(NW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]  MAX_V  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MIN_V  = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W-1:0] sat_root(input logic [NW-1:0] q, input logic neg);
    logic [W-1:0] r;
    if (!neg) begin
      r = (q > HALF_Q - NW'(1)) ? MAX_V : q[W-1:0];
    end else begin
      r = (q > HALF_Q) ? MIN_V : W'(-q[W-1:0]);
    end
    return r;
  endfunction

  logic           v4_q;
  logic [ODW-1:0] od4_q;
  logic           roots_ok;

  assign roots_ok = (dp_d[3:2] == ST_ROOTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      od4_q <= {dp_d[3:2],
                roots_ok ? sat_root(qm, dp_d[0]) : {W{1'b0}},
                roots_ok ? sat_root(qp, dp_d[1]) : {W{1'b0}}};
    end
  end

  // output register and skid stage
  logic           mv_q, skv_q;
  logic [ODW-1:0] md_q, skd_q;
  logic           out_free;

  assign out_free = !mv_q || m_axis_tready;
  assign en       = !skv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q  <= 1'b0;
      skv_q <= 1'b0;
    end else if (en) begin
      if (out_free) begin
        mv_q <= v4_q;
      end else if (v4_q) begin
        skv_q <= 1'b1;
      end
    end else if (m_axis_tready) begin
      skv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (out_free) begin
        md_q <= od4_q;
      end else begin
        skd_q <= od4_q;
      end
    end else if (m_axis_tready) begin
      md_q <= skd_q;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = mv_q;
  assign m_axis_tuser  = md_q[ODW-1 -: 2];
  assign m_axis_tdata  = OTW'(md_q[2*W-1:0]);

  `QRS_ASSERT(a_skid_needs_out, clk_i, rst_ni, !skv_q || mv_q)
  `QRS_ASSERT(a_stall_keeps_out, clk_i, rst_ni, (mv_q && !m_axis_tready) |=> mv_q)
  `QRS_ASSERT(a_skid_holds, clk_i, rst_ni, (skv_q && !m_axis_tready) |=> skv_q)
  `QRS_ASSERT(a_no_roots_zero, clk_i, rst_ni,
    !(m_axis_tvalid && m_axis_tuser != ST_ROOTS) || m_axis_tdata == '0)
  `QRS_ASSERT_RST(a_reset_empty, clk_i, !rst_ni |=> !mv_q)

endmodule
